FILE: rtl/nfp_pkg.sv
// Package for the nozzle flow predictor: beat types, command/status structs,
// fixed-point helpers and the microcode ROM. No dependencies.
package nfp_pkg;

    localparam int MAX_NODES = 64;
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 12;
    localparam int DIV_W     = 32 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int PC_W      = 7;
    localparam int SCR_DEPTH = 32;
    localparam int SCR_AW    = $clog2(SCR_DEPTH);

    localparam logic [31:0] Q_ONE  = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] Q_HALF = 32'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [1:0] CFG_GAMMA = 2'd0;
    localparam logic [1:0] CFG_DT    = 2'd1;
    localparam logic [1:0] CFG_PEXIT = 2'd2;

    localparam logic [17:0] GAMMA_RST = 18'd91750;
    localparam logic [16:0] DT_RST    = 17'd1311;
    localparam logic [16:0] PEXIT_RST = 17'd60948;

    typedef struct packed {
        logic signed [31:0] mass_term;
        logic signed [31:0] momentum_term;
        logic signed [31:0] energy_term;
        logic [30:0]        duct_area;
        logic signed [31:0] position;
        logic [30:0]        spacing;
        logic [30:0]        density;
        logic [30:0]        temperature;
        logic               final_node;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pred_mass;
        logic signed [31:0] pred_momentum;
        logic signed [31:0] pred_energy;
        logic signed [31:0] pred_density;
        logic signed [31:0] pred_temperature;
        logic               run_end;
    } result_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOV
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] dst;
        logic [5:0] srca;
        logic [5:0] srcb;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic load;
        logic ex;
        logic wb;
        logic fire;
        logic fire_end;
        logic push;
        logic commit;
        logic clear;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } status_t;

    // operand codes: 0..31 scratch slots, then named registers
    localparam logic [5:0] S0 = 6'd0,   S1 = 6'd1,   S2 = 6'd2,   S3 = 6'd3;
    localparam logic [5:0] S4 = 6'd4,   S5 = 6'd5,   S6 = 6'd6,   S7 = 6'd7;
    localparam logic [5:0] S8 = 6'd8,   S9 = 6'd9,   S10 = 6'd10, S11 = 6'd11;
    localparam logic [5:0] S12 = 6'd12, S13 = 6'd13, S14 = 6'd14, S15 = 6'd15;
    localparam logic [5:0] S16 = 6'd16, S17 = 6'd17, S18 = 6'd18;
    localparam logic [5:0] E1 = 6'd20,  E2 = 6'd21,  E3 = 6'd22,  EA = 6'd23;

    localparam logic [5:0] CUR0 = 6'd32, CUR1 = 6'd33, CUR2 = 6'd34, CUR3 = 6'd35;
    localparam logic [5:0] CUR4 = 6'd36, CUR5 = 6'd37, CUR6 = 6'd38, CUR7 = 6'd39;
    localparam logic [5:0] HN0 = 6'd40,  HN1 = 6'd41,  HN2 = 6'd42,  HN3 = 6'd43;
    localparam logic [5:0] HN4 = 6'd44,  HN5 = 6'd45,  HN6 = 6'd46,  HN7 = 6'd47;
    localparam logic [5:0] HF0 = 6'd48,  HF1 = 6'd49,  HF2 = 6'd50;
    localparam logic [5:0] NF0 = 6'd51,  NF1 = 6'd52,  NF2 = 6'd53;
    localparam logic [5:0] PH0 = 6'd54,  PH1 = 6'd55,  PH2 = 6'd56,  PH3 = 6'd57;
    localparam logic [5:0] K_ONE = 6'd58, K_HALF = 6'd59, K_G = 6'd60;
    localparam logic [5:0] K_DT = 6'd61,  K_PE = 6'd62,   K_ZERO = 6'd63;

    // named destinations
    localparam logic [5:0] D_NF0 = 6'd32, D_NF1 = 6'd33, D_NF2 = 6'd34;
    localparam logic [5:0] D_O0 = 6'd35,  D_O1 = 6'd36,  D_O2 = 6'd37;
    localparam logic [5:0] D_O3 = 6'd38,  D_O4 = 6'd39;

    // microcode segment entry points
    localparam logic [PC_W-1:0] SEG_FLUX   = 7'd0;
    localparam logic [PC_W-1:0] SEG_PRED   = 7'd19;
    localparam logic [PC_W-1:0] SEG_COPY   = 7'd43;
    localparam logic [PC_W-1:0] SEG_EMIT   = 7'd47;
    localparam logic [PC_W-1:0] SEG_EXTRAP = 7'd59;
    localparam logic [PC_W-1:0] SEG_PASS   = 7'd72;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = Q_MAX;
        else if (v < -64'sd2147483648)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic uop_t mk(input op_t op, input logic [5:0] dst,
                                input logic [5:0] a, input logic [5:0] b,
                                input logic last);
        uop_t u;
        u.op = op; u.dst = dst; u.srca = a; u.srcb = b; u.last = last;
        return u;
    endfunction

    function automatic uop_t rom_word(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // fluxes of the incoming node
            7'd0:  u = mk(OP_SUB, S0, K_G, K_ONE, 1'b0);
            7'd1:  u = mk(OP_MUL, S1, K_HALF, K_G, 1'b0);
            7'd2:  u = mk(OP_MUL, S2, CUR1, CUR1, 1'b0);
            7'd3:  u = mk(OP_DIV, S3, S2, CUR0, 1'b0);
            7'd4:  u = mk(OP_MUL, S4, S1, S3, 1'b0);
            7'd5:  u = mk(OP_SUB, S4, CUR2, S4, 1'b0);
            7'd6:  u = mk(OP_DIV, S5, S0, K_G, 1'b0);
            7'd7:  u = mk(OP_MUL, S5, S5, S4, 1'b0);
            7'd8:  u = mk(OP_ADD, D_NF1, S3, S5, 1'b0);
            7'd9:  u = mk(OP_MUL, S6, CUR1, CUR2, 1'b0);
            7'd10: u = mk(OP_DIV, S6, S6, CUR0, 1'b0);
            7'd11: u = mk(OP_MUL, S7, S2, CUR1, 1'b0);
            7'd12: u = mk(OP_MUL, S8, CUR0, CUR0, 1'b0);
            7'd13: u = mk(OP_DIV, S7, S7, S8, 1'b0);
            7'd14: u = mk(OP_MUL, S8, K_G, S6, 1'b0);
            7'd15: u = mk(OP_MUL, S9, S1, S0, 1'b0);
            7'd16: u = mk(OP_MUL, S9, S9, S7, 1'b0);
            7'd17: u = mk(OP_SUB, D_NF2, S8, S9, 1'b0);
            7'd18: u = mk(OP_MOV, D_NF0, CUR1, CUR1, 1'b1);
            // predictor for the held node
            7'd19: u = mk(OP_SUB, S10, CUR3, HN3, 1'b0);
            7'd20: u = mk(OP_SUB, S11, CUR4, HN4, 1'b0);
            7'd21: u = mk(OP_DIV, S10, S10, S11, 1'b0);
            7'd22: u = mk(OP_DIV, S11, K_ONE, K_G, 1'b0);
            7'd23: u = mk(OP_MUL, S11, S11, HN6, 1'b0);
            7'd24: u = mk(OP_MUL, S11, S11, HN7, 1'b0);
            7'd25: u = mk(OP_MUL, S11, S11, S10, 1'b0);
            7'd26: u = mk(OP_SUB, S12, NF0, HF0, 1'b0);
            7'd27: u = mk(OP_DIV, S12, S12, HN5, 1'b0);
            7'd28: u = mk(OP_SUB, S12, K_ZERO, S12, 1'b0);
            7'd29: u = mk(OP_SUB, S13, NF1, HF1, 1'b0);
            7'd30: u = mk(OP_DIV, S13, S13, HN5, 1'b0);
            7'd31: u = mk(OP_SUB, S13, K_ZERO, S13, 1'b0);
            7'd32: u = mk(OP_ADD, S13, S13, S11, 1'b0);
            7'd33: u = mk(OP_SUB, S14, NF2, HF2, 1'b0);
            7'd34: u = mk(OP_DIV, S14, S14, HN5, 1'b0);
            7'd35: u = mk(OP_SUB, S14, K_ZERO, S14, 1'b0);
            7'd36: u = mk(OP_MUL, E1, S12, K_DT, 1'b0);
            7'd37: u = mk(OP_ADD, E1, HN0, E1, 1'b0);
            7'd38: u = mk(OP_MUL, E2, S13, K_DT, 1'b0);
            7'd39: u = mk(OP_ADD, E2, HN1, E2, 1'b0);
            7'd40: u = mk(OP_MUL, E3, S14, K_DT, 1'b0);
            7'd41: u = mk(OP_ADD, E3, HN2, E3, 1'b0);
            7'd42: u = mk(OP_MOV, EA, HN3, HN3, 1'b1);
            // node 0: held values pass
            7'd43: u = mk(OP_MOV, E1, HN0, HN0, 1'b0);
            7'd44: u = mk(OP_MOV, E2, HN1, HN1, 1'b0);
            7'd45: u = mk(OP_MOV, E3, HN2, HN2, 1'b0);
            7'd46: u = mk(OP_MOV, EA, HN3, HN3, 1'b1);
            // result beat: U, density, temperature
            7'd47: u = mk(OP_MOV, D_O0, E1, E1, 1'b0);
            7'd48: u = mk(OP_MOV, D_O1, E2, E2, 1'b0);
            7'd49: u = mk(OP_MOV, D_O2, E3, E3, 1'b0);
            7'd50: u = mk(OP_DIV, D_O3, E1, EA, 1'b0);
            7'd51: u = mk(OP_DIV, S15, E2, E1, 1'b0);
            7'd52: u = mk(OP_DIV, S16, E3, E1, 1'b0);
            7'd53: u = mk(OP_MUL, S15, S15, S15, 1'b0);
            7'd54: u = mk(OP_MUL, S17, K_HALF, K_G, 1'b0);
            7'd55: u = mk(OP_MUL, S17, S17, S15, 1'b0);
            7'd56: u = mk(OP_SUB, S16, S16, S17, 1'b0);
            7'd57: u = mk(OP_SUB, S18, K_G, K_ONE, 1'b0);
            7'd58: u = mk(OP_MUL, D_O4, S18, S16, 1'b1);
            // outflow extrapolation
            7'd59: u = mk(OP_SUB, S0, K_G, K_ONE, 1'b0);
            7'd60: u = mk(OP_ADD, E1, PH0, PH0, 1'b0);
            7'd61: u = mk(OP_SUB, E1, E1, PH2, 1'b0);
            7'd62: u = mk(OP_ADD, E2, PH1, PH1, 1'b0);
            7'd63: u = mk(OP_SUB, E2, E2, PH3, 1'b0);
            7'd64: u = mk(OP_DIV, S1, E2, E1, 1'b0);
            7'd65: u = mk(OP_MUL, S2, K_PE, CUR3, 1'b0);
            7'd66: u = mk(OP_DIV, S2, S2, S0, 1'b0);
            7'd67: u = mk(OP_MUL, S3, K_HALF, K_G, 1'b0);
            7'd68: u = mk(OP_MUL, S3, S3, E2, 1'b0);
            7'd69: u = mk(OP_MUL, S3, S3, S1, 1'b0);
            7'd70: u = mk(OP_ADD, E3, S2, S3, 1'b0);
            7'd71: u = mk(OP_MOV, EA, CUR3, CUR3, 1'b1);
            // lone final node passes
            7'd72: u = mk(OP_MOV, E1, CUR0, CUR0, 1'b0);
            7'd73: u = mk(OP_MOV, E2, CUR1, CUR1, 1'b0);
            7'd74: u = mk(OP_MOV, E3, CUR2, CUR2, 1'b0);
            7'd75: u = mk(OP_MOV, EA, CUR3, CUR3, 1'b1);
            default: u = mk(OP_MOV, E1, K_ZERO, K_ZERO, 1'b1);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/nfp_ram.sv
// Generic scratch RAM: one write port, two registered read ports.
// No dependencies.
module nfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/nfp_div.sv
// Radix-2 restoring divider for the Q16.16 quotient (a << FRAC_BITS) / b,
// truncated toward zero and saturated. Depends on nfp_pkg.
module nfp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quo
);

    logic                               busy_reg;
    logic [nfp_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [31:0]                        rem_reg;
    logic [nfp_pkg::DIV_W-1:0]          dvd_reg;
    logic [31:0]                        den_reg;
    logic                               neg_reg;
    logic                               zero_reg;
    logic signed [31:0]                 zsat_reg;
    logic [32:0]                        rem_sh;
    logic                               ge;
    logic [31:0]                        num_mag;
    logic [31:0]                        den_mag;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);
    assign rem_sh  = {rem_reg, dvd_reg[nfp_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (den != 32'sd0);
            cnt_reg  <= nfp_pkg::DIV_CNT_W'(nfp_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != nfp_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= {num_mag, {nfp_pkg::FRAC_BITS{1'b0}}};
            den_reg  <= den_mag;
            neg_reg  <= num[31] ^ den[31];
            zero_reg <= (den == 32'sd0);
            zsat_reg <= num[31] ? nfp_pkg::Q_MIN : nfp_pkg::Q_MAX;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            dvd_reg <= {dvd_reg[nfp_pkg::DIV_W-2:0], ge};
        end
    end

    always_comb
    begin
        if (zero_reg)
            quo = zsat_reg;
        else if (neg_reg)
            quo = (dvd_reg > nfp_pkg::DIV_W'(64'h8000_0000)) ? nfp_pkg::Q_MIN
                                                           : 32'(-dvd_reg[31:0]);
        else
            quo = (dvd_reg > nfp_pkg::DIV_W'(64'h7fff_ffff)) ? nfp_pkg::Q_MAX
                                                           : 32'(dvd_reg[31:0]);
    end

    assign busy = busy_reg;

endmodule

FILE: rtl/nfp_dp.sv
// Datapath: config registers, node/flux/history state, operand muxes, shared
// multiplier and divider, scratch RAM, result register. Depends on nfp_pkg,
// nfp_ram, nfp_div.
module nfp_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [17:0]             cfg_data,
    input  nfp_pkg::item_t          item,
    input  nfp_pkg::cmd_t           cmd,
    output nfp_pkg::status_t        status,
    output logic                    result_valid,
    input  logic                    result_ready,
    output nfp_pkg::result_t        result
);

    logic [17:0]            gamma_reg;
    logic [16:0]            dt_reg;
    logic [16:0]            pe_reg;
    nfp_pkg::item_t         cur_reg;
    nfp_pkg::item_t         hn_reg;
    logic signed [31:0]     nf_reg [3];
    logic signed [31:0]     hf_reg [3];
    logic signed [31:0]     ph_reg [4];
    logic signed [31:0]     opa_reg;
    logic signed [31:0]     opb_reg;
    nfp_pkg::result_t       out_reg;
    logic                   out_valid_reg;

    logic [31:0]            ram_a;
    logic [31:0]            ram_b;
    logic signed [31:0]     opa;
    logic signed [31:0]     opb;
    logic signed [31:0]     res;
    logic signed [63:0]     prod;
    logic signed [63:0]     prod_sh;
    logic signed [31:0]     div_q;
    logic                   div_busy;
    logic                   div_start;
    logic                   ram_we;

    function automatic logic signed [31:0] pick(input logic [5:0] code,
                                                input logic [31:0] ram_data);
        logic signed [31:0] v;
        case (code)
            nfp_pkg::CUR0:   v = cur_reg.mass_term;
            nfp_pkg::CUR1:   v = cur_reg.momentum_term;
            nfp_pkg::CUR2:   v = cur_reg.energy_term;
            nfp_pkg::CUR3:   v = {1'b0, cur_reg.duct_area};
            nfp_pkg::CUR4:   v = cur_reg.position;
            nfp_pkg::CUR5:   v = {1'b0, cur_reg.spacing};
            nfp_pkg::CUR6:   v = {1'b0, cur_reg.density};
            nfp_pkg::CUR7:   v = {1'b0, cur_reg.temperature};
            nfp_pkg::HN0:    v = hn_reg.mass_term;
            nfp_pkg::HN1:    v = hn_reg.momentum_term;
            nfp_pkg::HN2:    v = hn_reg.energy_term;
            nfp_pkg::HN3:    v = {1'b0, hn_reg.duct_area};
            nfp_pkg::HN4:    v = hn_reg.position;
            nfp_pkg::HN5:    v = {1'b0, hn_reg.spacing};
            nfp_pkg::HN6:    v = {1'b0, hn_reg.density};
            nfp_pkg::HN7:    v = {1'b0, hn_reg.temperature};
            nfp_pkg::HF0:    v = hf_reg[0];
            nfp_pkg::HF1:    v = hf_reg[1];
            nfp_pkg::HF2:    v = hf_reg[2];
            nfp_pkg::NF0:    v = nf_reg[0];
            nfp_pkg::NF1:    v = nf_reg[1];
            nfp_pkg::NF2:    v = nf_reg[2];
            nfp_pkg::PH0:    v = ph_reg[0];
            nfp_pkg::PH1:    v = ph_reg[1];
            nfp_pkg::PH2:    v = ph_reg[2];
            nfp_pkg::PH3:    v = ph_reg[3];
            nfp_pkg::K_ONE:  v = nfp_pkg::Q_ONE;
            nfp_pkg::K_HALF: v = nfp_pkg::Q_HALF;
            nfp_pkg::K_G:    v = {14'd0, gamma_reg};
            nfp_pkg::K_DT:   v = {15'd0, dt_reg};
            nfp_pkg::K_PE:   v = {15'd0, pe_reg};
            nfp_pkg::K_ZERO: v = '0;
            default:         v = ram_data;
        endcase
        return v;
    endfunction

    nfp_ram #(
        .WIDTH (32),
        .DEPTH (nfp_pkg::SCR_DEPTH)
    ) u_scratch (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (cmd.uop.dst[nfp_pkg::SCR_AW-1:0]),
        .wdata   (res),
        .raddr_a (cmd.uop.srca[nfp_pkg::SCR_AW-1:0]),
        .raddr_b (cmd.uop.srcb[nfp_pkg::SCR_AW-1:0]),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    assign div_start = cmd.ex && (cmd.uop.op == nfp_pkg::OP_DIV);

    nfp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .busy  (div_busy),
        .quo   (div_q)
    );

    // operand select follows the state registers as well as the codes
    always_comb
    begin
        opa = pick(cmd.uop.srca, ram_a);
        opb = pick(cmd.uop.srcb, ram_b);
    end

    assign prod    = opa_reg * opb_reg;
    assign prod_sh = prod >>> nfp_pkg::FRAC_BITS;

    always_comb
    begin
        case (cmd.uop.op)
            nfp_pkg::OP_ADD: res = nfp_pkg::sat64(64'(opa_reg) + 64'(opb_reg));
            nfp_pkg::OP_SUB: res = nfp_pkg::sat64(64'(opa_reg) - 64'(opb_reg));
            nfp_pkg::OP_MUL: res = nfp_pkg::sat64(prod_sh);
            nfp_pkg::OP_DIV: res = div_q;
            default:         res = opa_reg;
        endcase
    end

    assign ram_we = cmd.wb && !cmd.uop.dst[5];

    // config and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg     <= nfp_pkg::GAMMA_RST;
            dt_reg        <= nfp_pkg::DT_RST;
            pe_reg        <= nfp_pkg::PEXIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    nfp_pkg::CFG_GAMMA: gamma_reg <= cfg_data;
                    nfp_pkg::CFG_DT:    dt_reg    <= cfg_data[16:0];
                    nfp_pkg::CFG_PEXIT: pe_reg    <= cfg_data[16:0];
                    default:            ;
                endcase
            end
            if (cmd.fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // run state (cleared at the end of a run)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hn_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                hf_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                ph_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            hn_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                hf_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                ph_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                hn_reg <= cur_reg;
                for (int i = 0; i < 3; i++)
                begin
                    hf_reg[i] <= nf_reg[i];
                end
            end
            if (cmd.push)
            begin
                ph_reg[2] <= ph_reg[0];
                ph_reg[3] <= ph_reg[1];
                ph_reg[0] <= out_reg.pred_mass;
                ph_reg[1] <= out_reg.pred_momentum;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            cur_reg <= item;
        if (cmd.ex)
        begin
            opa_reg <= opa;
            opb_reg <= opb;
        end
        if (cmd.fire)
            out_reg.run_end <= cmd.fire_end;
        if (cmd.wb)
        begin
            case (cmd.uop.dst)
                nfp_pkg::D_NF0: nf_reg[0]                <= res;
                nfp_pkg::D_NF1: nf_reg[1]                <= res;
                nfp_pkg::D_NF2: nf_reg[2]                <= res;
                nfp_pkg::D_O0:  out_reg.pred_mass        <= res;
                nfp_pkg::D_O1:  out_reg.pred_momentum    <= res;
                nfp_pkg::D_O2:  out_reg.pred_energy      <= res;
                nfp_pkg::D_O3:  out_reg.pred_density     <= res;
                nfp_pkg::D_O4:  out_reg.pred_temperature <= res;
                default:        ;
            endcase
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_busy = out_valid_reg;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

endmodule

FILE: rtl/nfp_ctrl.sv
// Controller: run bookkeeping and the microcode sequencer that drives the
// datapath one micro-op at a time. Depends on nfp_pkg.
module nfp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                final_node,
    input  nfp_pkg::status_t    status,
    output logic                item_ready,
    output nfp_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_DIV,
        ST_WB,
        ST_WAIT,
        ST_END
    } state_t;

    typedef enum logic [2:0] {
        PH_FLUX,
        PH_BODY,
        PH_EMIT1,
        PH_TAIL,
        PH_EMIT2
    } phase_t;

    state_t                     state_reg;
    phase_t                     phase_reg;
    logic [nfp_pkg::PC_W-1:0]   pc_reg;
    logic [nfp_pkg::CNT_W-1:0]  cnt_reg;
    logic                       hp_reg;
    logic                       last_reg;
    logic                       fire_reg;
    logic                       fire_end_reg;
    logic                       push_reg;
    logic                       commit_reg;
    logic                       clear_reg;
    nfp_pkg::uop_t              uop;

    assign uop        = nfp_pkg::rom_word(pc_reg);
    assign item_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_FLUX;
            pc_reg       <= '0;
            cnt_reg      <= '0;
            hp_reg       <= 1'b0;
            last_reg     <= 1'b0;
            fire_reg     <= 1'b0;
            fire_end_reg <= 1'b0;
            push_reg     <= 1'b0;
            commit_reg   <= 1'b0;
            clear_reg    <= 1'b0;
        end
        else
        begin
            fire_reg   <= 1'b0;
            push_reg   <= 1'b0;
            commit_reg <= 1'b0;
            clear_reg  <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        last_reg  <= final_node ||
                                     (cnt_reg >= nfp_pkg::CNT_W'(nfp_pkg::MAX_NODES - 1));
                        pc_reg    <= nfp_pkg::SEG_FLUX;
                        phase_reg <= PH_FLUX;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_EX;
                end
                ST_EX:
                begin
                    state_reg <= (uop.op == nfp_pkg::OP_DIV) ? ST_DIV : ST_WB;
                end
                ST_DIV:
                begin
                    if (!status.div_busy)
                        state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    if (!uop.last)
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_FLUX:
                            begin
                                if (hp_reg)
                                begin
                                    pc_reg    <= (cnt_reg <= nfp_pkg::CNT_W'(1)) ?
                                                 nfp_pkg::SEG_COPY : nfp_pkg::SEG_PRED;
                                    phase_reg <= PH_BODY;
                                    state_reg <= ST_RD;
                                end
                                else if (last_reg)
                                begin
                                    pc_reg    <= nfp_pkg::SEG_PASS;
                                    phase_reg <= PH_TAIL;
                                    state_reg <= ST_RD;
                                end
                                else
                                begin
                                    commit_reg <= 1'b1;
                                    hp_reg     <= 1'b1;
                                    cnt_reg    <= cnt_reg + 1'b1;
                                    state_reg  <= ST_END;
                                end
                            end
                            PH_BODY:
                            begin
                                phase_reg <= PH_EMIT1;
                                state_reg <= ST_WAIT;
                            end
                            PH_EMIT1:
                            begin
                                fire_reg     <= 1'b1;
                                fire_end_reg <= 1'b0;
                                push_reg     <= 1'b1;
                                if (last_reg)
                                begin
                                    pc_reg    <= nfp_pkg::SEG_EXTRAP;
                                    phase_reg <= PH_TAIL;
                                    state_reg <= ST_RD;
                                end
                                else
                                begin
                                    commit_reg <= 1'b1;
                                    cnt_reg    <= cnt_reg + 1'b1;
                                    state_reg  <= ST_END;
                                end
                            end
                            PH_TAIL:
                            begin
                                phase_reg <= PH_EMIT2;
                                state_reg <= ST_WAIT;
                            end
                            default:
                            begin
                                fire_reg     <= 1'b1;
                                fire_end_reg <= 1'b1;
                                clear_reg    <= 1'b1;
                                cnt_reg      <= '0;
                                hp_reg       <= 1'b0;
                                state_reg    <= ST_END;
                            end
                        endcase
                    end
                end
                ST_WAIT:
                begin
                    if (!status.out_busy)
                    begin
                        pc_reg    <= nfp_pkg::SEG_EMIT;
                        state_reg <= ST_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.load     = item_valid && (state_reg == ST_IDLE);
        cmd.ex       = (state_reg == ST_EX);
        cmd.wb       = (state_reg == ST_WB);
        cmd.fire     = fire_reg;
        cmd.fire_end = fire_end_reg;
        cmd.push     = push_reg;
        cmd.commit   = commit_reg;
        cmd.clear    = clear_reg;
        cmd.uop      = uop;
    end

endmodule

FILE: rtl/nozzle_flow_predictor_step.sv
// MacCormack predictor step for a quasi-1D nozzle, Q16.16 fixed point.
// Top level: controller plus datapath. Depends on nfp_pkg, nfp_ctrl, nfp_dp.
//
// Grid nodes of a run stream in on the item channel, node 0 first; each
// node's result beat leaves when the following node has come in, and the
// final node (final_node set, or the node at index MAX_NODES-1) also yields
// the outflow beat with run_end set, so the final node gives two beats and a
// lone final node gives one. All math runs through one shared sequencer: a
// microcode ROM steps a multiplier (one per micro-op), a radix-2 divider
// (DIV_W = 48 steps) and a 32-entry scratch RAM. Each micro-op steps
// through read, execute and write back, and a divide waits between execute
// and write back until the divider is no longer busy. Item ready is high
// only while the sequencer is idle; a finished beat sits in the output
// register and the next node is taken while it waits. Config writes
// (gamma, dt, exit pressure) land on the next edge and must only be made
// while the block is idle. Divide by zero saturates to the extreme value
// with the dividend's sign.
module nozzle_flow_predictor_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [17:0]         cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  nfp_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_ready,
    output nfp_pkg::result_t    result
);

    nfp_pkg::cmd_t      cmd;
    nfp_pkg::status_t   status;

    nfp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .final_node (item.final_node),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    nfp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // one node in flight: after a beat is taken the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item taken while sequencer busy");

    // divider is never restarted mid-division
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ex && (cmd.uop.op == nfp_pkg::OP_DIV)) |-> !status.div_busy)
        else $error("divider restarted while busy");

    // a result beat is only launched into an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> !result_valid)
        else $error("result beat overwritten");

endmodule

FILE: bench/nozzle_flow_predictor_step_tb.sv
// Testbench for nozzle_flow_predictor_step: streams nozzle grid runs, predicts
// every result beat in Q16.16 and checks it. Depends on nfp_pkg and the RTL.
`timescale 1ns / 100ps

module nozzle_flow_predictor_step_tb;

    localparam int WATCHDOG_LIMIT = 20000;   // cycles with no beat moving
    localparam int SETTLE_CYCLES  = 1200;    // settle margin after the expected beats are drained
    localparam int Q_MAX_I = 32'sh7fff_ffff;
    localparam int Q_MIN_I = 32'sh8000_0000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [17:0]        cfg_data;
    logic               item_valid;
    logic               item_ready;
    nfp_pkg::item_t     item;
    logic               result_valid;
    logic               result_ready;
    nfp_pkg::result_t   result;

    nozzle_flow_predictor_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Mirror of the block: registers and per-run state.
    int unsigned gamma_q, dt_q, pexit_q;
    int          held_in[8];
    int          held_fx[3];
    int          last_preds[4];   // U1, U2 of newest emitted node, then the one before
    int unsigned node_idx;
    bit          node_held;

    nfp_pkg::result_t expected_beats[$];
    int      errors;
    bit      idling;              // both sides draw random gaps while set
    int      stall_left;
    int      quiet_cycles;
    int      run_pos;             // running x coordinate for shaped runs

    always #5 clk = ~clk;

    // ---------------- Q16.16 arithmetic ----------------
    function automatic int q_sat(longint v);
        if (v > longint'(Q_MAX_I))
            return Q_MAX_I;
        if (v < longint'(Q_MIN_I))
            return Q_MIN_I;
        return int'(v);
    endfunction

    function automatic int q_add(int a, int b);
        return q_sat(longint'(a) + longint'(b));
    endfunction

    function automatic int q_sub(int a, int b);
        return q_sat(longint'(a) - longint'(b));
    endfunction

    function automatic int q_neg(int a);
        return q_sat(-longint'(a));
    endfunction

    // floor of the product, i.e. arithmetic shift of the 64-bit value
    function automatic int q_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return q_sat(p >>> nfp_pkg::FRAC_BITS);
    endfunction

    // truncates toward zero; zero divisor saturates by the dividend's sign
    function automatic int q_div(int a, int b);
        if (b == 0)
            return (a >= 0) ? Q_MAX_I : Q_MIN_I;
        return q_sat((longint'(a) <<< nfp_pkg::FRAC_BITS) / longint'(b));
    endfunction

    // ---------------- node physics ----------------
    function automatic void node_fluxes(int u1, int u2, int u3, output int f[3]);
        int g, gm1, hg, t1, t2, s1, s2;
        g   = int'(gamma_q);
        gm1 = q_sub(g, int'(nfp_pkg::Q_ONE));
        hg  = q_mul(int'(nfp_pkg::Q_HALF), g);
        t1  = q_div(q_mul(u2, u2), u1);
        t2  = q_sub(u3, q_mul(hg, t1));
        f[0] = u2;
        f[1] = q_add(t1, q_mul(q_div(gm1, g), t2));
        s1 = q_div(q_mul(u2, u3), u1);
        s2 = q_div(q_mul(q_mul(u2, u2), u2), q_mul(u1, u1));
        f[2] = q_sub(q_mul(g, s1), q_mul(q_mul(hg, gm1), s2));
    endfunction

    // result beat: U terms plus density and temperature derived from them
    function automatic nfp_pkg::result_t flow_beat(int u1, int u2, int u3, int area,
                                                   bit fin);
        nfp_pkg::result_t r;
        int g, gm1, vel, e_ratio, v2;
        g       = int'(gamma_q);
        gm1     = q_sub(g, int'(nfp_pkg::Q_ONE));
        vel     = q_div(u2, u1);
        e_ratio = q_div(u3, u1);
        v2      = q_mul(vel, vel);
        r.pred_mass        = u1;
        r.pred_momentum    = u2;
        r.pred_energy      = u3;
        r.pred_density     = q_div(u1, area);
        r.pred_temperature = q_mul(gm1, q_sub(e_ratio,
                                 q_mul(q_mul(int'(nfp_pkg::Q_HALF), g), v2)));
        r.run_end          = fin;
        return r;
    endfunction

    function automatic void clear_run_state();
        foreach (held_in[i]) held_in[i] = 0;
        foreach (held_fx[i]) held_fx[i] = 0;
        foreach (last_preds[i]) last_preds[i] = 0;
        node_idx  = 0;
        node_held = 0;
    endfunction

    // Queues the beats caused by one accepted node.
    function automatic void predict_node(nfp_pkg::item_t it);
        int c[8];
        int f[3];
        int p1, p2, p3, g, gm1, slope, j2, d1, d2, d3, e1, e2, e3, vel;
        bit last;
        c[0] = it.mass_term;
        c[1] = it.momentum_term;
        c[2] = it.energy_term;
        c[3] = int'({1'b0, it.duct_area});
        c[4] = it.position;
        c[5] = int'({1'b0, it.spacing});
        c[6] = int'({1'b0, it.density});
        c[7] = int'({1'b0, it.temperature});
        last = it.final_node || (node_idx >= nfp_pkg::MAX_NODES - 1);
        g    = int'(gamma_q);
        gm1  = q_sub(g, int'(nfp_pkg::Q_ONE));
        node_fluxes(c[0], c[1], c[2], f);

        if (node_held)
        begin
            if (node_idx <= 1)
            begin
                // node 0 passes unchanged
                p1 = held_in[0];
                p2 = held_in[1];
                p3 = held_in[2];
            end
            else
            begin
                slope = q_div(q_sub(c[3], held_in[3]), q_sub(c[4], held_in[4]));
                j2 = q_mul(q_mul(q_mul(q_div(int'(nfp_pkg::Q_ONE), g), held_in[6]),
                                 held_in[7]), slope);
                d1 = q_neg(q_div(q_sub(f[0], held_fx[0]), held_in[5]));
                d2 = q_add(q_neg(q_div(q_sub(f[1], held_fx[1]), held_in[5])), j2);
                d3 = q_neg(q_div(q_sub(f[2], held_fx[2]), held_in[5]));
                p1 = q_add(held_in[0], q_mul(d1, int'(dt_q)));
                p2 = q_add(held_in[1], q_mul(d2, int'(dt_q)));
                p3 = q_add(held_in[2], q_mul(d3, int'(dt_q)));
            end
            expected_beats.push_back(flow_beat(p1, p2, p3, held_in[3], 1'b0));
            last_preds[2] = last_preds[0];
            last_preds[3] = last_preds[1];
            last_preds[0] = p1;
            last_preds[1] = p2;
        end

        if (last)
        begin
            if (node_held)
            begin
                // outflow: linear extrapolation, U3 from exit pressure
                e1  = q_sub(q_add(last_preds[0], last_preds[0]), last_preds[2]);
                e2  = q_sub(q_add(last_preds[1], last_preds[1]), last_preds[3]);
                vel = q_div(e2, e1);
                e3  = q_add(q_div(q_mul(int'(pexit_q), c[3]), gm1),
                            q_mul(q_mul(q_mul(int'(nfp_pkg::Q_HALF), g), e2), vel));
                expected_beats.push_back(flow_beat(e1, e2, e3, c[3], 1'b1));
            end
            else
            begin
                expected_beats.push_back(flow_beat(c[0], c[1], c[2], c[3], 1'b1));
            end
            clear_run_state();
        end
        else
        begin
            foreach (c[i]) held_in[i] = c[i];
            foreach (f[i]) held_fx[i] = f[i];
            node_held = 1;
            node_idx  = (node_idx + 1) & 32'h0000_0fff;
        end
    endfunction

    // ---------------- result side ----------------
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat %p", $time, result);
                errors++;
            end
            else
            begin
                nfp_pkg::result_t want;
                want = expected_beats.pop_front();
                if (result.pred_mass !== want.pred_mass)
                begin
                    $display("%0t: pred_mass exp %0d got %0d", $time,
                             want.pred_mass, result.pred_mass);
                    errors++;
                end
                if (result.pred_momentum !== want.pred_momentum)
                begin
                    $display("%0t: pred_momentum exp %0d got %0d", $time,
                             want.pred_momentum, result.pred_momentum);
                    errors++;
                end
                if (result.pred_energy !== want.pred_energy)
                begin
                    $display("%0t: pred_energy exp %0d got %0d", $time,
                             want.pred_energy, result.pred_energy);
                    errors++;
                end
                if (result.pred_density !== want.pred_density)
                begin
                    $display("%0t: pred_density exp %0d got %0d", $time,
                             want.pred_density, result.pred_density);
                    errors++;
                end
                if (result.pred_temperature !== want.pred_temperature)
                begin
                    $display("%0t: pred_temperature exp %0d got %0d", $time,
                             want.pred_temperature, result.pred_temperature);
                    errors++;
                end
                if (result.run_end !== want.run_end)
                begin
                    $display("%0t: run_end exp %0b got %0b", $time,
                             want.run_end, result.run_end);
                    errors++;
                end
            end
            stall_left = idling ? int'($urandom_range(0, 10)) : 0;
        end
    end

    // receiver back-pressure, drawn per beat
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left    = stall_left - 1;
        end
        else
            result_ready <= 1'b1;
    end

    // watchdog: any beat moving on either side resets the count
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nozzle_flow_predictor_step_tb: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    // Entered and left at a falling edge. Valid stays up between back-to-back
    // beats so it is never dropped and raised in the same step.
    task automatic send_node(nfp_pkg::item_t it);
        int gap;
        gap = idling ? int'($urandom_range(0, 10)) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        predict_node(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        // a node with no beat may still be in the sequencer
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            nfp_pkg::CFG_GAMMA: gamma_q = 32'(val);
            nfp_pkg::CFG_DT:    dt_q    = 32'(val[16:0]);
            nfp_pkg::CFG_PEXIT: pexit_q = 32'(val[16:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [17:0] g, logic [17:0] dt, logic [17:0] pe);
        wait_drained();
        write_reg(nfp_pkg::CFG_GAMMA, g);
        write_reg(nfp_pkg::CFG_DT, dt);
        write_reg(nfp_pkg::CFG_PEXIT, pe);
    endtask

    // shaped nodes look like a real nozzle; the rest is raw noise
    function automatic nfp_pkg::item_t rand_node(bit shaped, bit fin);
        nfp_pkg::item_t it;
        if (shaped)
        begin
            it.mass_term     = $urandom_range(32'h0000_4000, 32'h0003_0000);
            it.momentum_term = $urandom_range(32'h0000_2000, 32'h0002_0000);
            it.energy_term   = $urandom_range(32'h0000_8000, 32'h0006_0000);
            it.duct_area     = 31'($urandom_range(32'h0000_8000, 32'h0006_0000));
            it.spacing       = 31'($urandom_range(32'h0000_0100, 32'h0000_2000));
            it.position      = run_pos;
            it.density       = 31'($urandom_range(32'h0000_4000, 32'h0002_0000));
            it.temperature   = 31'($urandom_range(32'h0000_4000, 32'h0002_0000));
            run_pos          = run_pos + int'({1'b0, it.spacing});
        end
        else
        begin
            it.mass_term     = $urandom;
            it.momentum_term = $urandom;
            it.energy_term   = $urandom;
            it.duct_area     = 31'($urandom);
            it.position      = $urandom;
            it.spacing       = 31'($urandom_range(1, 32'h7fff_ffff));
            it.density       = 31'($urandom);
            it.temperature   = 31'($urandom);
        end
        it.final_node = fin;
        return it;
    endfunction

    task automatic send_run(int len, bit shaped);
        run_pos = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        for (int i = 0; i < len; i++)
            send_node(rand_node(shaped, i == len - 1));
    endtask

    // ---------------- tests ----------------
    task automatic test_edge_runs();
        nfp_pkg::item_t it;
        // lone final node, then the shortest run that extrapolates
        send_run(1, 1'b1);
        send_run(2, 1'b1);
        send_run(5, 1'b1);
        // field extremes: max everything, min everything with zero area
        it.mass_term = Q_MAX_I;  it.momentum_term = Q_MAX_I; it.energy_term = Q_MAX_I;
        it.duct_area = 31'h7fff_ffff; it.position = Q_MAX_I; it.spacing = 31'h7fff_ffff;
        it.density = 31'h7fff_ffff; it.temperature = 31'h7fff_ffff; it.final_node = 1'b0;
        send_node(it);
        it.mass_term = Q_MIN_I;  it.momentum_term = Q_MIN_I; it.energy_term = Q_MIN_I;
        it.duct_area = '0; it.position = Q_MIN_I; it.spacing = 31'd1;
        it.density = '0; it.temperature = '0;
        send_node(it);
        // zero U1 and repeated x: the divides by U1 and by the x step see a zero divisor
        it.mass_term = 0; it.momentum_term = -5; it.energy_term = 7;
        send_node(it);
        it.momentum_term = 3; it.duct_area = 31'h1_0000;
        it.final_node = 1'b1;
        send_node(it);
        // lone final node with zero everything
        it = '0;
        it.spacing = 31'd1;
        it.final_node = 1'b1;
        send_node(it);
    endtask

    // no final flag: the node at index MAX_NODES-1 closes the run
    task automatic test_overlong_run();
        run_pos = 0;
        for (int i = 0; i < nfp_pkg::MAX_NODES; i++)
            send_node(rand_node(1'b1, 1'b0));
        send_run(3, 1'b1);
    endtask

    task automatic test_register_sweep();
        set_regs(18'd0, 18'd0, 18'd0);
        repeat (3) send_run($urandom_range(1, 5), 1'b1);
        set_regs(18'd65536, 18'd65536, 18'd65536);
        repeat (3) send_run($urandom_range(1, 5), 1'b1);
        set_regs(18'h3ffff, 18'h1ffff, 18'h1ffff);
        repeat (3) send_run($urandom_range(1, 5), 1'b1);
        set_regs(18'd65537, 18'd1, 18'd30000);
        repeat (3) send_run($urandom_range(1, 5), 1'b1);
        set_regs(18'd196608, 18'd4096, 18'd0);
        repeat (3) send_run($urandom_range(1, 5), 1'b1);
        set_regs(nfp_pkg::GAMMA_RST, 18'(nfp_pkg::DT_RST), 18'(nfp_pkg::PEXIT_RST));
    endtask

    task automatic test_random_runs();
        int sent;
        bit drained_once;
        sent = 0;
        drained_once = 0;
        while (sent < 1350)
        begin
            int len;
            bit shaped;
            len    = $urandom_range(1, 10);
            shaped = ($urandom_range(0, 99) < 80);
            if ($urandom_range(0, 7) == 0)
                idling = ~idling;
            if (!drained_once && sent > 600)
            begin
                // mid-run hold-off until every beat is home
                run_pos = 0;
                send_node(rand_node(1'b1, 1'b0));
                send_node(rand_node(1'b1, 1'b0));
                item_valid <= 1'b0;
                while (expected_beats.size() != 0) @(posedge clk);
                @(negedge clk);
                send_node(rand_node(1'b1, 1'b1));
                sent += 3;
                drained_once = 1;
            end
            send_run(len, shaped);
            sent += len;
        end
        idling = 1;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        errors       = 0;
        idling       = 1;
        stall_left   = 0;
        quiet_cycles = 0;
        gamma_q      = 32'(nfp_pkg::GAMMA_RST);
        dt_q         = 32'(nfp_pkg::DT_RST);
        pexit_q      = 32'(nfp_pkg::PEXIT_RST);
        clear_run_state();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_edge_runs();
        test_overlong_run();
        test_register_sweep();
        test_random_runs();

        wait_drained();
        if (errors == 0)
            $display("nozzle_flow_predictor_step_tb: done, clean");
        else
            $display("nozzle_flow_predictor_step_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/nfp_pkg.sv
rtl/nfp_ram.sv
rtl/nfp_div.sv
rtl/nfp_dp.sv
rtl/nfp_ctrl.sv
rtl/nozzle_flow_predictor_step.sv
bench/nozzle_flow_predictor_step_tb.sv
